/* rtl/core/ehodo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ehodo_pkg;

  // Number format and iteration setup
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int CNT_W        = $clog2(CORDIC_N);
  localparam int TAB_W        = $clog2(TAB_LEN);

  // Heading alignment: bring the top 16 fraction bits to bits [15:0]
  localparam int A16_RSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int A16_LSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  // Datapath widths
  localparam int XW   = 34;  // CORDIC x, y in Q2.30 plus guard
  localparam int ZW   = 33;  // residual angle, 2^-32 turn units
  localparam int DW   = 33;  // travel deltas
  localparam int SCW  = 30;  // sine, cosine in Q28
  localparam int PW   = DW + SCW;  // product
  localparam int SW   = 64;  // product sum
  localparam int RW   = SW - 28;  // rounded delta
  localparam int ACW  = RW + 1;  // accumulator sum before saturation

  localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);
  localparam logic signed [SW-1:0] RND_HALF = SW'(64'd1 << 27);

  // Microprogram
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] STEP_LOAD   = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_CORDIC = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_FOLD   = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_MUL0   = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_MUL1   = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_MUL2   = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_MUL3   = PC_W'(6);
  localparam logic [PC_W-1:0] STEP_SUMY   = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_UPDY   = PC_W'(8);
  localparam logic [PC_W-1:0] STEP_EMIT   = PC_W'(9);
  localparam logic [PC_W-1:0] STEP_CLR    = PC_W'(10);

  typedef enum logic [2:0] {
    OP_NOP, OP_LOAD, OP_CLEAR, OP_CORDIC, OP_FOLD, OP_UPD_X, OP_UPD_Y, OP_EMIT
  } dp_op_e;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_LAT_C, MUL_FWD_S, MUL_FWD_C, MUL_LAT_S
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_SET, ACC_ADD, ACC_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    WAIT_NONE, WAIT_IN, WAIT_OUT
  } wait_e;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_ALWAYS, JMP_IF_CLEAR, JMP_IF_MORE
  } jump_e;

  typedef struct packed {
    dp_op_e            op;
    mul_sel_e          mul;
    acc_op_e           acc;
    wait_e             wt;
    jump_e             jmp;
    logic [PC_W-1:0]   target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic clear_op;
    logic more;
    logic out_free;
  } seq_status_t;

  function automatic ctrl_word_t mk_word(input dp_op_e op, input mul_sel_e mul,
                                         input acc_op_e acc, input wait_e wt,
                                         input jump_e jmp, input logic [PC_W-1:0] target);
    ctrl_word_t w;
    w.op     = op;
    w.mul    = mul;
    w.acc    = acc;
    w.wt     = wt;
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      STEP_LOAD:   w = mk_word(OP_LOAD,   MUL_NONE,  ACC_NONE, WAIT_IN,   JMP_IF_CLEAR, STEP_CLR);
      STEP_CORDIC: w = mk_word(OP_CORDIC, MUL_NONE,  ACC_NONE, WAIT_NONE, JMP_IF_MORE,  STEP_CORDIC);
      STEP_FOLD:   w = mk_word(OP_FOLD,   MUL_NONE,  ACC_NONE, WAIT_NONE, JMP_NEXT,     STEP_LOAD);
      STEP_MUL0:   w = mk_word(OP_NOP,    MUL_LAT_C, ACC_NONE, WAIT_NONE, JMP_NEXT,     STEP_LOAD);
      STEP_MUL1:   w = mk_word(OP_NOP,    MUL_FWD_S, ACC_SET,  WAIT_NONE, JMP_NEXT,     STEP_LOAD);
      STEP_MUL2:   w = mk_word(OP_NOP,    MUL_FWD_C, ACC_ADD,  WAIT_NONE, JMP_NEXT,     STEP_LOAD);
      STEP_MUL3:   w = mk_word(OP_UPD_X,  MUL_LAT_S, ACC_SET,  WAIT_NONE, JMP_NEXT,     STEP_LOAD);
      STEP_SUMY:   w = mk_word(OP_NOP,    MUL_NONE,  ACC_SUB,  WAIT_NONE, JMP_NEXT,     STEP_LOAD);
      STEP_UPDY:   w = mk_word(OP_UPD_Y,  MUL_NONE,  ACC_NONE, WAIT_NONE, JMP_NEXT,     STEP_LOAD);
      STEP_EMIT:   w = mk_word(OP_EMIT,   MUL_NONE,  ACC_NONE, WAIT_OUT,  JMP_ALWAYS,   STEP_LOAD);
      STEP_CLR:    w = mk_word(OP_CLEAR,  MUL_NONE,  ACC_NONE, WAIT_NONE, JMP_ALWAYS,   STEP_EMIT);
      default:     w = mk_word(OP_NOP,    MUL_NONE,  ACC_NONE, WAIT_NONE, JMP_ALWAYS,   STEP_LOAD);
    endcase
    return w;
  endfunction

  // atan(2^-i) in 2^-32 turn units
  function automatic logic signed [ZW-1:0] atan_turns(input logic [TAB_W-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = ZW'(536870912);
      5'd1:    v = ZW'(316933406);
      5'd2:    v = ZW'(167458907);
      5'd3:    v = ZW'(85004756);
      5'd4:    v = ZW'(42667331);
      5'd5:    v = ZW'(21354465);
      5'd6:    v = ZW'(10679838);
      5'd7:    v = ZW'(5340245);
      5'd8:    v = ZW'(2670163);
      5'd9:    v = ZW'(1335087);
      5'd10:   v = ZW'(667544);
      5'd11:   v = ZW'(333772);
      5'd12:   v = ZW'(166886);
      5'd13:   v = ZW'(83443);
      5'd14:   v = ZW'(41722);
      5'd15:   v = ZW'(20861);
      5'd16:   v = ZW'(10430);
      5'd17:   v = ZW'(5215);
      5'd18:   v = ZW'(2608);
      5'd19:   v = ZW'(1304);
      5'd20:   v = ZW'(652);
      5'd21:   v = ZW'(326);
      5'd22:   v = ZW'(163);
      5'd23:   v = ZW'(81);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] heading_to_a16(input logic [31:0] h);
    return 16'((h >> A16_RSH) << A16_LSH);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACW-1:0] v);
    logic signed [ACW-1:0] hi;
    logic signed [ACW-1:0] lo;
    hi = ACW'(64'sh7FFF_FFFF);
    lo = -ACW'(64'sh8000_0000);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ehodo_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module ehodo_seq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ehodo_pkg::seq_status_t status_i,
  output ehodo_pkg::ctrl_word_t       ctrl_o,
  output logic                        exec_o
);

  logic [ehodo_pkg::PC_W-1:0] pc_q, pc_d;
  ehodo_pkg::ctrl_word_t      word;
  logic                       go;
  logic                       taken;

  assign word = ehodo_pkg::ucode(pc_q);

  // Hold the step while its wait condition is not met
  always_comb begin
    unique case (word.wt)
      ehodo_pkg::WAIT_NONE: go = 1'b1;
      ehodo_pkg::WAIT_IN:   go = status_i.in_valid;
      ehodo_pkg::WAIT_OUT:  go = status_i.out_free;
      default:              go = 1'b0;
    endcase
  end

  always_comb begin
    unique case (word.jmp)
      ehodo_pkg::JMP_NEXT:     taken = 1'b0;
      ehodo_pkg::JMP_ALWAYS:   taken = 1'b1;
      ehodo_pkg::JMP_IF_CLEAR: taken = status_i.clear_op;
      ehodo_pkg::JMP_IF_MORE:  taken = status_i.more;
      default:                 taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (go) begin
      pc_d = taken ? word.target : pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ehodo_pkg::STEP_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = word;
  assign exec_o = go;

endmodule

`default_nettype wire

/* rtl/core/ehodo_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module ehodo_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 exec_i,
  input  wire ehodo_pkg::ctrl_word_t ctrl_i,
  input  wire logic                 mode_i,
  input  wire logic                 op_i,
  input  wire logic signed [31:0]   heading_turns_i,
  input  wire logic signed [31:0]   enc_a_i,
  input  wire logic signed [31:0]   enc_b_i,
  output logic signed [31:0]        acc_x_o,
  output logic signed [31:0]        acc_y_o,
  output logic [15:0]               a16_o,
  output logic                      more_o
);

  localparam int XW  = ehodo_pkg::XW;
  localparam int ZW  = ehodo_pkg::ZW;
  localparam int DW  = ehodo_pkg::DW;
  localparam int SCW = ehodo_pkg::SCW;
  localparam int PW  = ehodo_pkg::PW;
  localparam int SW  = ehodo_pkg::SW;
  localparam int RW  = ehodo_pkg::RW;
  localparam int ACW = ehodo_pkg::ACW;
  localparam int CNT_W = ehodo_pkg::CNT_W;

  // Architectural state
  logic signed [31:0] prev_fwd_q, prev_lat_q;
  logic signed [31:0] acc_x_q, acc_y_q;
  logic [CNT_W-1:0]   iter_q;

  // Working registers
  logic signed [DW-1:0]  dfwd_q, dlat_q;
  logic signed [XW-1:0]  cx_q, cy_q;
  logic signed [ZW-1:0]  cz_q;
  logic [1:0]            quad_q;
  logic [15:0]           a16_q;
  logic signed [SCW-1:0] cos_q, sin_q;
  logic signed [PW-1:0]  prod_q;
  logic signed [SW-1:0]  sum_q;

  logic                  do_load, do_update;
  logic [15:0]           a16_in;
  logic signed [32:0]    enc_sum;
  logic signed [31:0]    fwd, lat;
  logic signed [XW-1:0]  sh_x, sh_y;
  logic signed [ZW-1:0]  atan_v;
  logic signed [XW-1:0]  c_rnd, s_rnd;
  logic signed [SCW-1:0] c_fold, s_fold;
  logic signed [DW-1:0]  mul_a;
  logic signed [SCW-1:0] mul_b;
  logic signed [PW-1:0]  prod_w;
  logic signed [RW-1:0]  delta_rnd;
  logic signed [31:0]    acc_sel;
  logic signed [31:0]    acc_new;

  assign do_load   = exec_i && (ctrl_i.op == ehodo_pkg::OP_LOAD);
  assign do_update = do_load && !op_i;

  assign a16_in = ehodo_pkg::heading_to_a16(heading_turns_i);

  // Travel from the encoders
  assign enc_sum = 33'(enc_a_i) + 33'(enc_b_i);
  always_comb begin
    if (mode_i) begin
      lat = enc_a_i;
      fwd = enc_b_i;
    end else begin
      lat = '0;
      fwd = enc_sum[32:1];
    end
  end

  // One CORDIC rotation step
  assign sh_x   = cx_q >>> iter_q;
  assign sh_y   = cy_q >>> iter_q;
  assign atan_v = ehodo_pkg::atan_turns(ehodo_pkg::TAB_W'(iter_q));
  assign more_o = (iter_q != CNT_W'(ehodo_pkg::CORDIC_N - 1));

  // Round to Q28 and fold back into the full turn
  assign c_rnd = (cx_q + XW'(2)) >>> 2;
  assign s_rnd = (cy_q + XW'(2)) >>> 2;
  always_comb begin
    unique case (quad_q)
      2'd0: begin c_fold = SCW'(c_rnd);  s_fold = SCW'(s_rnd);  end
      2'd1: begin c_fold = -SCW'(s_rnd); s_fold = SCW'(c_rnd);  end
      2'd2: begin c_fold = -SCW'(c_rnd); s_fold = -SCW'(s_rnd); end
      default: begin c_fold = SCW'(s_rnd); s_fold = -SCW'(c_rnd); end
    endcase
  end

  // Shared multiplier
  always_comb begin
    unique case (ctrl_i.mul)
      ehodo_pkg::MUL_LAT_C: begin mul_a = dlat_q; mul_b = cos_q; end
      ehodo_pkg::MUL_FWD_S: begin mul_a = dfwd_q; mul_b = sin_q; end
      ehodo_pkg::MUL_FWD_C: begin mul_a = dfwd_q; mul_b = cos_q; end
      ehodo_pkg::MUL_LAT_S: begin mul_a = dlat_q; mul_b = sin_q; end
      default:              begin mul_a = '0;     mul_b = '0;    end
    endcase
  end
  assign prod_w = PW'(mul_a) * PW'(mul_b);

  // Round the sum to the position LSB and add with saturation
  assign delta_rnd = RW'((sum_q + ehodo_pkg::RND_HALF) >>> 28);
  assign acc_sel   = (ctrl_i.op == ehodo_pkg::OP_UPD_X) ? acc_x_q : acc_y_q;
  assign acc_new   = ehodo_pkg::sat32(ACW'(acc_sel) + ACW'(delta_rnd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_fwd_q <= '0;
      prev_lat_q <= '0;
      acc_x_q    <= '0;
      acc_y_q    <= '0;
      iter_q     <= '0;
    end else if (exec_i) begin
      if (do_update) begin
        prev_fwd_q <= fwd;
        prev_lat_q <= lat;
      end
      if (ctrl_i.op == ehodo_pkg::OP_LOAD) begin
        iter_q <= '0;
      end
      if (ctrl_i.op == ehodo_pkg::OP_CORDIC) begin
        iter_q <= iter_q + 1'b1;
      end
      if (ctrl_i.op == ehodo_pkg::OP_CLEAR) begin
        acc_x_q <= '0;
        acc_y_q <= '0;
      end
      if (ctrl_i.op == ehodo_pkg::OP_UPD_X) begin
        acc_x_q <= acc_new;
      end
      if (ctrl_i.op == ehodo_pkg::OP_UPD_Y) begin
        acc_y_q <= acc_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      a16_q  <= a16_in;
      quad_q <= a16_in[15:14];
      cz_q   <= ZW'({a16_in[13:0], 16'h0000});
      cx_q   <= ehodo_pkg::GAIN_Q30;
      cy_q   <= '0;
      dfwd_q <= DW'(fwd) - DW'(prev_fwd_q);
      dlat_q <= DW'(lat) - DW'(prev_lat_q);
    end
    if (exec_i && ctrl_i.op == ehodo_pkg::OP_CORDIC) begin
      if (!cz_q[ZW-1]) begin
        cx_q <= cx_q - sh_y;
        cy_q <= cy_q + sh_x;
        cz_q <= cz_q - atan_v;
      end else begin
        cx_q <= cx_q + sh_y;
        cy_q <= cy_q - sh_x;
        cz_q <= cz_q + atan_v;
      end
    end
    if (exec_i && ctrl_i.op == ehodo_pkg::OP_FOLD) begin
      cos_q <= c_fold;
      sin_q <= s_fold;
    end
    if (exec_i && ctrl_i.mul != ehodo_pkg::MUL_NONE) begin
      prod_q <= prod_w;
    end
    if (exec_i) begin
      unique case (ctrl_i.acc)
        ehodo_pkg::ACC_SET: sum_q <= SW'(prod_q);
        ehodo_pkg::ACC_ADD: sum_q <= sum_q + SW'(prod_q);
        ehodo_pkg::ACC_SUB: sum_q <= sum_q - SW'(prod_q);
        default:            sum_q <= sum_q;
      endcase
    end
  end

  assign acc_x_o = acc_x_q;
  assign acc_y_o = acc_y_q;
  assign a16_o   = a16_q;

endmodule

`default_nettype wire

/* rtl/core/encoder_heading_odometry_top.sv */
// Wheel odometry with heading: each input transaction carries an absolute
// heading (turns, Q16.16) and two encoder positions (revolutions, Q16.16).
// An update op forms forward and lateral travel per the sensor_mode register
// (0: forward is the floor mean of both encoders, no lateral; 1: enc_a is
// lateral, enc_b is forward), takes deltas against the previous travel,
// rotates them by the top 16 fraction bits of the heading and adds them to a
// saturating field position. A clear op zeroes the position and keeps the
// previous travel. Every input transaction yields exactly one output
// transaction with pos_x, pos_y and the 16-bit heading fraction used.
// Timing: a microprogram steps one shared CORDIC stage and one shared
// 33x30 multiplier. An update steps through load, the CORDIC loop, fold,
// the multiply steps, a sum, the y update and emit; a clear steps through
// load, clear and emit. Input is taken again in the cycle after the result
// loads, while the result waits in its own output register. Write
// sensor_mode only while the block is idle; the write port never stalls.
`timescale 1ns / 1ps
`default_nettype none

module encoder_heading_odometry_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_sensor_mode_i,
  // input sample channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               op_i,
  input  wire logic signed [31:0] heading_turns_i,
  input  wire logic signed [31:0] enc_a_i,
  input  wire logic signed [31:0] enc_b_i,
  // output position channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic [15:0]             heading_out_o
);

  ehodo_pkg::ctrl_word_t  ctrl;
  ehodo_pkg::seq_status_t status;
  logic                   exec;
  logic                   more;
  logic                   mode_q;
  logic                   out_valid_q, out_valid_d;
  logic                   emit;
  logic signed [31:0]     acc_x, acc_y;
  logic [15:0]            a16;
  logic signed [31:0]     pos_x_q, pos_y_q;
  logic [15:0]            heading_q;

  // Configuration register: always ready, one bit
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_sensor_mode_i;
    end
  end

  // Accept an input transaction only at the load step of the microprogram
  assign in_ready_o = (ctrl.wt == ehodo_pkg::WAIT_IN);

  assign status.in_valid = in_valid_i;
  assign status.clear_op = op_i;
  assign status.more     = more;
  assign status.out_free = !out_valid_q || out_ready_i;

  ehodo_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .exec_o   (exec)
  );

  ehodo_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .exec_i          (exec),
    .ctrl_i          (ctrl),
    .mode_i          (mode_q),
    .op_i            (op_i),
    .heading_turns_i (heading_turns_i),
    .enc_a_i         (enc_a_i),
    .enc_b_i         (enc_b_i),
    .acc_x_o         (acc_x),
    .acc_y_o         (acc_y),
    .a16_o           (a16),
    .more_o          (more)
  );

  // Load the output register at the emit step; it waits there for the sink
  assign emit = exec && (ctrl.op == ehodo_pkg::OP_EMIT);

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pos_x_q   <= acc_x;
      pos_y_q   <= acc_y;
      heading_q <= a16;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = pos_x_q;
  assign pos_y_o       = pos_y_q;
  assign heading_out_o = heading_q;

endmodule

`default_nettype wire
